[hdl/chm_pkg.sv]
// Package for the chained hash map: request and response payload types
// and the command and status codes. No dependencies.
package chm_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [8:0]  entry_count;
    } rsp_t;

endpackage

[hdl/chained_hash_map.sv]
// Chained hash map top level: bucket heads, node pool and the chain walker.
// Depends on chm_pkg.
//
// After a request transfer, S_HASH computes the quotient of the key and S_HEAD
// reduces the key to its bucket and reads the bucket head. Each node of the
// chain then passes through S_NODE, where it is read, and S_CMP, where its key
// is compared; a key that is not in the chain takes one more S_NODE and S_CMP
// pass. A remove that hits, or an insert that takes a never-used node, then
// passes through S_FREE; an insert that reuses a freed node passes through
// S_FRDY and S_FREE. After reset the bucket head memory is cleared, during
// which no request is taken. The result sits in an output register, and the
// next request can transfer in the cycle after the result transfer.
module chained_hash_map #(
    parameter int BUCKETS = 64,
    parameter int ENTRIES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  chm_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output chm_pkg::rsp_t m_data
);
    import chm_pkg::*;

    localparam int LW = $clog2(ENTRIES + 1);
    localparam int NW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int HS = $clog2(BUCKETS);
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);
    // Rounded-up reciprocal of BUCKETS; the quotient is exact for 32-bit keys.
    localparam logic [65:0] RECIP = ((66'd1 << (32 + HS)) / 66'(BUCKETS)) + 66'd1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_NODE  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_FRDY  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [LW-1:0] head_mem [BUCKETS];
    logic [31:0]   key_mem  [ENTRIES];
    logic [31:0]   val_mem  [ENTRIES];
    logic [LW-1:0] next_mem [ENTRIES];

    logic [3:0]    state_reg;
    logic [BW-1:0] clr_reg;
    req_t          req_reg;
    logic [BW-1:0] q_reg;
    logic [BW-1:0] bkt_reg;
    logic [LW-1:0] cur_reg, prev_reg;
    logic [LW:0]   steps_reg;
    logic [LW-1:0] free_reg, fresh_cnt_reg;
    logic [LW-1:0] count_reg;
    rsp_t          rsp_reg;
    logic          mv_reg;
    // The tail link of an appended node is written in the cycle after the node.
    logic          link_pend_reg;

    // Registered memory read ports.
    logic [LW-1:0] head_rd;
    logic [31:0]   key_rd, val_rd;
    logic [LW-1:0] next_rd;
    logic [NW-1:0] node_addr;
    logic [BW-1:0] head_addr;

    logic          h_we;
    logic [BW-1:0] h_wa;
    logic [LW-1:0] h_wd;
    logic          k_we, v_we, n_we;
    logic [NW-1:0] k_wa, v_wa, n_wa;
    logic [31:0]   k_wd, v_wd;
    logic [LW-1:0] n_wd;

    logic [65:0]   q_prod;
    logic [BW-1:0] q_next;
    logic [BW-1:0] bkt_next;

    always_ff @(posedge aclk) begin
        if (h_we) head_mem[h_wa] <= h_wd;
        head_rd <= head_mem[head_addr];
        if (k_we) key_mem[k_wa] <= k_wd;
        if (v_we) val_mem[v_wa] <= v_wd;
        if (n_we) next_mem[n_wa] <= n_wd;
        key_rd  <= key_mem[node_addr];
        val_rd  <= val_mem[node_addr];
        next_rd <= next_mem[node_addr];
    end

    logic [3:0]    state_next;
    logic [LW-1:0] cur_next, prev_next, free_next, fresh_cnt_next;
    logic [LW:0]   steps_next;
    logic [LW-1:0] count_next;
    rsp_t          rsp_next;
    logic          mv_next;
    logic          cur_ok;

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = rsp_reg;
    assign cur_ok  = (cur_reg != NIL) && (steps_reg < (LW+1)'(ENTRIES));

    // The bucket is the key minus quotient times BUCKETS; only its low bits matter.
    assign q_prod   = 66'(req_reg.key) * RECIP;
    assign q_next   = BW'(q_prod >> (32 + HS));
    assign bkt_next = req_reg.key[BW-1:0] - BW'(q_reg * BW'(BUCKETS));

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        steps_next = steps_reg;
        free_next = free_reg;
        fresh_cnt_next = fresh_cnt_reg;
        count_next = count_reg;
        rsp_next = rsp_reg;
        mv_next = mv_reg && !m_ready;
        node_addr = cur_reg[NW-1:0];
        head_addr = bkt_reg;
        h_we = 1'b0; h_wa = bkt_reg; h_wd = NIL;
        k_we = 1'b0; k_wa = cur_reg[NW-1:0]; k_wd = req_reg.key;
        v_we = 1'b0; v_wa = cur_reg[NW-1:0]; v_wd = req_reg.value;
        n_we = 1'b0; n_wa = cur_reg[NW-1:0]; n_wd = NIL;
        case (state_reg)
            S_CLEAR: begin
                h_we = 1'b1;
                h_wa = clr_reg;
                if (clr_reg == BW'(BUCKETS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cur_next = NIL;
                    prev_next = NIL;
                    steps_next = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                state_next = S_HEAD;
            end
            S_HEAD: begin
                head_addr = bkt_next;
                state_next = S_NODE;
            end
            S_NODE: begin
                if (steps_reg == '0 && prev_reg == NIL && cur_reg == NIL) begin
                    // First node of the walk comes straight from the head read.
                    cur_next = head_rd;
                    node_addr = head_rd[NW-1:0];
                end
                state_next = S_CMP;
            end
            S_CMP: begin
                // Node reads for cur_reg were issued in the previous cycle.
                if (cur_ok && key_rd == req_reg.key) begin
                    rsp_next = '{ST_OK, 32'd0, 9'(count_reg)};
                    state_next = S_OUT;
                    case (req_reg.command)
                        CMD_LOOKUP: rsp_next.read_value = val_rd;
                        CMD_INSERT: v_we = 1'b1;
                        CMD_REMOVE: begin
                            if (prev_reg != NIL) begin
                                n_we = 1'b1;
                                n_wa = prev_reg[NW-1:0];
                                n_wd = next_rd;
                            end else begin
                                h_we = 1'b1;
                                h_wd = next_rd;
                            end
                            state_next = S_FREE;
                        end
                        default: ;
                    endcase
                end else if (cur_ok) begin
                    prev_next = cur_reg;
                    cur_next = next_rd;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_NODE;
                end else begin
                    rsp_next = '{ST_NOT_FOUND, 32'd0, 9'(count_reg)};
                    state_next = S_OUT;
                    if (req_reg.command == CMD_INSERT) begin
                        if (free_reg != NIL) begin
                            node_addr = free_reg[NW-1:0];
                            state_next = S_FRDY;
                        end else if (fresh_cnt_reg < NIL) begin
                            cur_next = fresh_cnt_reg;
                            fresh_cnt_next = fresh_cnt_reg + 1'b1;
                            state_next = S_FREE;
                        end else begin
                            rsp_next.status = ST_FULL;
                        end
                    end else if (req_reg.command != CMD_LOOKUP &&
                                 req_reg.command != CMD_REMOVE) begin
                        rsp_next.status = ST_OK;
                    end
                end
            end
            S_FRDY: begin
                cur_next = free_reg;
                free_next = next_rd;
                state_next = S_FREE;
            end
            S_FREE: begin
                state_next = S_OUT;
                if (req_reg.command == CMD_REMOVE) begin
                    n_we = 1'b1;
                    n_wd = free_reg;
                    free_next = cur_reg;
                    if (count_reg != '0) count_next = count_reg - 1'b1;
                end else begin
                    k_we = 1'b1;
                    v_we = 1'b1;
                    n_we = 1'b1;
                    if (prev_reg == NIL) begin
                        h_we = 1'b1;
                        h_wd = cur_reg;
                    end
                    count_next = count_reg + 1'b1;
                end
                rsp_next = '{ST_OK, 32'd0, 9'(count_next)};
            end
            S_OUT: begin
                if (link_pend_reg && prev_reg != NIL) begin
                    n_we = 1'b1;
                    n_wa = prev_reg[NW-1:0];
                    n_wd = cur_reg;
                end
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            free_reg <= NIL;
            fresh_cnt_reg <= '0;
            count_reg <= '0;
            mv_reg <= 1'b0;
            link_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_reg + 1'b1;
            free_reg <= free_next;
            fresh_cnt_reg <= fresh_cnt_next;
            count_reg <= count_next;
            mv_reg <= mv_next;
            link_pend_reg <= (state_reg == S_FREE) && (req_reg.command == CMD_INSERT);
        end
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        steps_reg <= steps_next;
        rsp_reg <= rsp_next;
        if (s_valid && s_ready) req_reg <= s_data;
        if (state_reg == S_HASH) q_reg <= q_next;
        if (state_reg == S_HEAD) bkt_reg <= bkt_next;
    end

endmodule

[hdl/chm_checker.sv]
// Port-level checker for the chained hash map, bound to the top level.
// Depends on chm_pkg.
module chm_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input chm_pkg::req_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input chm_pkg::rsp_t m_data
);
    import chm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken during a walk");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_NOT_FOUND ||
                     m_data.status == ST_FULL))
        else $error("unknown status");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.read_value == 32'd0)
        else $error("miss with nonzero value");

endmodule

bind chained_hash_map chm_checker u_chm_checker (.*);

[bench/chained_hash_map_tb.sv]
// Testbench for the chained hash map: directed and random requests with a
// shadow map predictor and an in-order response checker. Depends on chm_pkg.
module chained_hash_map_tb;
    import chm_pkg::*;

    localparam int BUCKETS = 64;
    localparam int ENTRIES = 256;
    localparam int NIL = ENTRIES;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_data;

    chained_hash_map #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shadow copy of the map.
    int          head_of[BUCKETS];
    logic [31:0] key_of[ENTRIES];
    logic [31:0] val_of[ENTRIES];
    int          next_of[ENTRIES];
    int          free_head;
    int          fresh_used;
    int          stored;

    rsp_t        pending_rsp[$];
    logic [31:0] key_pool[$];
    int          errors;
    int          cycles;
    bit          rx_busy;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int find_node(input logic [31:0] k, output int prev);
        int cur;
        int steps;
        cur = head_of[k % BUCKETS];
        prev = NIL;
        steps = 0;
        while (cur != NIL && steps < ENTRIES) begin
            if (key_of[cur] == k) return cur;
            prev = cur;
            cur = next_of[cur];
            steps++;
        end
        return NIL;
    endfunction

    function automatic rsp_t map_apply(input req_t r);
        rsp_t o;
        int hit;
        int prev;
        int fresh;
        o = '0;
        o.status = ST_OK;
        hit = find_node(r.key, prev);
        case (r.command)
            CMD_LOOKUP: begin
                if (hit != NIL) o.read_value = val_of[hit];
                else o.status = ST_NOT_FOUND;
            end
            CMD_INSERT: begin
                if (hit != NIL) begin
                    val_of[hit] = r.value;
                end else begin
                    fresh = NIL;
                    if (free_head != NIL) begin
                        fresh = free_head;
                        free_head = next_of[fresh];
                    end else if (fresh_used < ENTRIES) begin
                        fresh = fresh_used;
                        fresh_used++;
                    end
                    if (fresh != NIL) begin
                        key_of[fresh] = r.key;
                        val_of[fresh] = r.value;
                        next_of[fresh] = NIL;
                        if (prev != NIL) next_of[prev] = fresh;
                        else head_of[r.key % BUCKETS] = fresh;
                        stored++;
                    end else begin
                        o.status = ST_FULL;
                    end
                end
            end
            CMD_REMOVE: begin
                if (hit != NIL) begin
                    if (prev != NIL) next_of[prev] = next_of[hit];
                    else head_of[r.key % BUCKETS] = next_of[hit];
                    next_of[hit] = free_head;
                    free_head = hit;
                    if (stored > 0) stored--;
                end else begin
                    o.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        o.entry_count = stored[8:0];
        return o;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [31:0] k,
                                input logic [31:0] v);
        req_t r;
        r.command = cmd;
        r.key = k;
        r.value = v;
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        pending_rsp.push_back(map_apply(r));
        if (cmd == CMD_INSERT) key_pool.push_back(k);
    endtask

    // Burst pacing: after each transfer either keep valid high or insert a gap.
    int burst_left;
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic send_paced(input logic [1:0] cmd, input logic [31:0] k,
                              input logic [31:0] v);
        send_request(cmd, k, v);
        pace();
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if ($urandom_range(0, 1))
            return {4'($urandom_range(0, 15)), 28'd0} |
                   32'($urandom_range(0, 7) * BUCKETS + 5);
        return $urandom;
    endfunction

    // Receiver stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (rx_busy) m_ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
        else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response %p", $time, m_data);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    errors++;
                end
                if (m_data.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, m_data.read_value);
                    errors++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, m_data.entry_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_basic_commands();
        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0, 32'hA5A5_5A5A);
        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        // Keys sharing one bucket build a chain; remove head, middle and tail.
        send_request(CMD_INSERT, 32'd64, 32'd1);
        send_request(CMD_INSERT, 32'd128, 32'd2);
        send_request(CMD_INSERT, 32'd192, 32'd3);
        send_request(CMD_REMOVE, 32'd64, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'd192, 32'h0);
        send_request(CMD_LOOKUP, 32'd128, 32'h0);
        send_request(CMD_REMOVE, 32'd0, 32'h0);
        send_request(CMD_LOOKUP, 32'd0, 32'h0);
        send_request(CMD_UNUSED, 32'h1234_5678, 32'hDEAD_BEEF);
        // Freed nodes come back last-freed first.
        send_request(CMD_INSERT, 32'd256, 32'd4);
        send_request(CMD_INSERT, 32'd320, 32'd5);
        send_request(CMD_LOOKUP, 32'd320, 32'h0);
        s_valid <= 1'b0;
    endtask

    task automatic test_pool_exhaustion();
        int i;
        // Fill the pool, overflow it, then drain some, refill and drain again.
        for (i = 0; i < ENTRIES + 6; i++)
            send_paced(CMD_INSERT, $urandom_range(0, 3) * 32'h0100_0000 + i * 7,
                       $urandom);
        for (i = 0; i < 40; i++)
            send_paced(CMD_REMOVE, pick_key(), $urandom);
        for (i = 0; i < 50; i++)
            send_paced(CMD_INSERT, $urandom, $urandom);
        for (i = 0; i < ENTRIES + 10; i++)
            send_paced(CMD_REMOVE, pick_key(), $urandom);
        s_valid <= 1'b0;
    endtask

    task automatic test_random_mix();
        int i;
        int sel;
        logic [1:0] cmd;
        for (i = 0; i < 700; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) cmd = CMD_INSERT;
            else if (sel < 70) cmd = CMD_LOOKUP;
            else if (sel < 97) cmd = CMD_REMOVE;
            else cmd = CMD_UNUSED;
            send_paced(cmd, pick_key(), $urandom);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int i;
        burst_left = 0;
        rx_busy = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        for (i = 0; i < BUCKETS; i++) head_of[i] = NIL;
        for (i = 0; i < ENTRIES; i++) next_of[i] = NIL;
        free_head = NIL;
        fresh_used = 0;
        stored = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_commands();
        rx_busy = 1'b1;
        test_pool_exhaustion();
        test_random_mix();

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (2 * ENTRIES + 20) @(posedge aclk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

[sim.f]
hdl/chm_pkg.sv
hdl/chained_hash_map.sv
hdl/chm_checker.sv
bench/chained_hash_map_tb.sv
